// ===== rtl/cqc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue calculator package
// Shared command, operation and status codes and datapath control types.
// ----------------------------------------------------------------------------
package cqc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_DROP = 2'd2,
        CMD_RUN  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_DROP     = 3'd3,
        ST_DIVZERO  = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_NEXT,
        S_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;    // take the input beat into the datapath registers
        logic do_cmd;     // execute push, pop or drop, or start a run
        logic rd_entry;   // read the current queue entry
        logic exec;       // apply an add, sub or mul, or a divide by zero
        logic div_start;  // start the divider
        logic div_step;   // one divider iteration
        logic div_end;    // write back the quotient
        logic advance;    // move to the next entry
        logic out_load;   // load the result register
    } ctrl_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_run;     // captured command is a run on a nonempty queue
        logic is_div;     // current entry is a divide with a nonzero operand
        logic div_done;   // divider has finished its iterations
        logic last;       // current entry is the last of the run
    } stat_t;

endpackage

// ===== rtl/cqc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue calculator controller
// Sequences one command at a time and walks the queue during a run.
// ----------------------------------------------------------------------------
module cqc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_busy,
    input  cqc_pkg::stat_t  st,
    output cqc_pkg::ctrl_t  ctl,
    output logic            ready
);
    import cqc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_READ;
            S_READ: state_next = st.is_run ? S_EXEC : S_DONE;
            S_EXEC: state_next = st.is_div ? S_DIV : S_NEXT;
            S_DIV:  if (st.div_done) state_next = S_NEXT;
            S_NEXT: state_next = st.last ? S_DONE : S_EXEC;
            S_DONE: if (!out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                ready = 1'b1;
                ctl.capture = in_fire;
            end
            S_READ: begin
                ctl.do_cmd = 1'b1;
                ctl.rd_entry = 1'b1;
            end
            S_EXEC: begin
                ctl.exec = !st.is_div;
                ctl.div_start = st.is_div;
            end
            S_DIV: begin
                ctl.div_step = !st.div_done;
                ctl.div_end = st.div_done;
            end
            S_NEXT: begin
                ctl.advance = 1'b1;
                ctl.rd_entry = 1'b1;
            end
            S_DONE: ctl.out_load = !out_busy;
            default: ;
        endcase
    end

endmodule

// ===== rtl/cqc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue calculator datapath
// Queue storage, pointers, Q16.16 arithmetic and a radix-2 divider.
// ----------------------------------------------------------------------------
module cqc_datapath #(
    parameter int QUEUE_DEPTH = cqc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cqc_pkg::ctrl_t       ctl,
    output cqc_pkg::stat_t       st,
    input  logic [1:0]           command,
    input  logic [1:0]           operation,
    input  logic signed [31:0]   operand,
    input  logic [4:0]           drop_count,
    input  logic signed [31:0]   start_value,
    output logic signed [31:0]   result_value,
    output logic [4:0]           queue_count,
    output logic [2:0]           status
);
    import cqc_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic signed [63:0] QMAX = 64'sd2147483647;
    localparam logic signed [63:0] QMIN = -64'sd2147483648;

    logic [1:0]  op_mem  [QUEUE_DEPTH];
    logic [31:0] val_mem [QUEUE_DEPTH];

    logic [IW-1:0] oldest_reg;
    logic [CW-1:0] count_reg;

    logic [1:0]           cmd_reg, op_in_reg, rd_op_reg;
    logic signed [31:0]   opd_reg, rd_val_reg;
    logic [4:0]           drop_reg;
    logic signed [31:0]   acc_reg;
    logic [2:0]           stat_reg;
    logic [CW-1:0]        idx_reg;

    // Divider: |acc|<<16 over |operand|, 48-bit dividend.
    logic [47:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic [31:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_reg;

    logic [IW-1:0] slot;
    logic [IW-1:0] wr_slot;
    logic [CW:0]   sum_wide;

    function automatic logic [IW-1:0] wrap(input logic [CW:0] v);
        logic [CW:0] m;
        m = v;
        if (m >= (CW+1)'(QUEUE_DEPTH))
            m = m - (CW+1)'(QUEUE_DEPTH);
        return m[IW-1:0];
    endfunction

    // While advancing, the entry after the current one is fetched.
    assign sum_wide = (CW+1)'(oldest_reg) + (CW+1)'(idx_reg) + (CW+1)'(ctl.advance);
    assign slot     = wrap(sum_wide);
    assign wr_slot  = wrap((CW+1)'(oldest_reg) + (CW+1)'(count_reg));

    // Queue memory.
    always_ff @(posedge clk)
    begin
        if (ctl.do_cmd && cmd_reg == CMD_PUSH && count_reg < CW'(QUEUE_DEPTH)) begin
            op_mem[wr_slot]  <= op_in_reg;
            val_mem[wr_slot] <= opd_reg;
        end
        if (ctl.rd_entry) begin
            rd_op_reg  <= op_mem[slot];
            rd_val_reg <= val_mem[slot];
        end
    end

    // Arithmetic for add, sub and mul.
    logic signed [63:0] a64, v64, sum64, prod64, shr64, res64;
    logic               ovf;
    assign a64    = 64'(acc_reg);
    assign v64    = 64'(rd_val_reg);
    assign sum64  = (rd_op_reg == OP_SUB) ? a64 - v64 : a64 + v64;
    assign prod64 = a64 * v64;
    assign shr64  = prod64 >>> 16;
    always_comb
    begin
        res64 = (rd_op_reg == OP_MUL) ? shr64 : sum64;
        ovf = 1'b0;
        if (res64 > QMAX) begin
            res64 = QMAX;
            ovf = 1'b1;
        end else if (res64 < QMIN) begin
            res64 = QMIN;
            ovf = 1'b1;
        end
    end

    // Divider step.
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    assign rem_sh  = {rem_reg, dvd_reg[47]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    logic signed [63:0] qs64, qsat;
    logic               qovf;
    always_comb
    begin
        qs64 = dneg_reg ? -$signed({16'd0, dvd_reg}) : $signed({16'd0, dvd_reg});
        qsat = qs64;
        qovf = 1'b0;
        if (qs64 > QMAX) begin
            qsat = QMAX;
            qovf = 1'b1;
        end else if (qs64 < QMIN) begin
            qsat = QMIN;
            qovf = 1'b1;
        end
    end

    assign st.is_run   = (cmd_reg == CMD_RUN) && (count_reg != '0);
    assign st.is_div   = (rd_op_reg == OP_DIV) && (rd_val_reg != '0);
    assign st.div_done = (dcnt_reg == 6'd48);
    assign st.last     = (idx_reg + CW'(1) >= count_reg);

    // A divide reaching the exec path has a zero operand.
    logic [2:0] flag;
    always_comb
    begin
        flag = ST_OK;
        if (rd_op_reg == OP_DIV)
            flag = ST_DIVZERO;
        else if (ovf)
            flag = ST_OVERFLOW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            oldest_reg <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
        end else begin
            if (ctl.capture)
                idx_reg <= '0;
            if (ctl.advance)
                idx_reg <= idx_reg + CW'(1);
            if (ctl.do_cmd) begin
                case (cmd_reg)
                    CMD_PUSH: if (count_reg < CW'(QUEUE_DEPTH))
                        count_reg <= count_reg + CW'(1);
                    CMD_POP: if (count_reg != '0) begin
                        oldest_reg <= wrap((CW+1)'(oldest_reg) + (CW+1)'(1));
                        count_reg  <= count_reg - CW'(1);
                    end
                    CMD_DROP: if (6'(drop_reg) <= 6'(count_reg))
                        count_reg <= count_reg - CW'(drop_reg);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture) begin
            cmd_reg   <= command;
            op_in_reg <= operation;
            opd_reg   <= operand;
            drop_reg  <= drop_count;
            acc_reg   <= start_value;
            stat_reg  <= ST_OK;
        end
        if (ctl.do_cmd) begin
            case (cmd_reg)
                CMD_PUSH: if (count_reg >= CW'(QUEUE_DEPTH)) stat_reg <= ST_FULL;
                CMD_POP:  if (count_reg == '0) stat_reg <= ST_EMPTY;
                CMD_DROP: if (6'(drop_reg) > 6'(count_reg)) stat_reg <= ST_DROP;
                default:  if (count_reg == '0) stat_reg <= ST_EMPTY;
            endcase
        end
        if (ctl.exec) begin
            if (rd_op_reg == OP_DIV)
                acc_reg <= (acc_reg > 0) ? 32'sh7FFFFFFF :
                           (acc_reg < 0) ? 32'sh80000000 : 32'sd0;
            else
                acc_reg <= res64[31:0];
            if (stat_reg == ST_OK) stat_reg <= flag;
        end
        if (ctl.div_start) begin
            dvd_reg  <= {(acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg)), 16'd0};
            dvs_reg  <= rd_val_reg[31] ? 32'(-rd_val_reg) : 32'(rd_val_reg);
            rem_reg  <= '0;
            dcnt_reg <= '0;
            dneg_reg <= acc_reg[31] ^ rd_val_reg[31];
        end
        if (ctl.div_step) begin
            if (!rem_sub[32]) begin
                rem_reg <= rem_sub[31:0];
                dvd_reg <= {dvd_reg[46:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[31:0];
                dvd_reg <= {dvd_reg[46:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 6'd1;
        end
        if (ctl.div_end) begin
            acc_reg <= qsat[31:0];
            if (stat_reg == ST_OK && qovf) stat_reg <= ST_OVERFLOW;
        end
    end

    assign result_value = (cmd_reg == CMD_RUN) ? acc_reg : 32'sd0;
    assign queue_count  = 5'(count_reg);
    assign status       = stat_reg;

endmodule

// ===== rtl/command_queue_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue calculator
// Bounded queue of Q16.16 arithmetic commands with push, pop, drop and run.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// s_axis  | in        | command, operation, operand, drop_count, start_value
// m_axis  | out       | result_value, queue_count, status
//
// Push, pop and drop go from accept through read to result. A run works
// through the queue entries in order and passes each divide entry with
// a nonzero operand through the radix-2 divider, one quotient bit a cycle.
// One command is in flight at a time; the input is freed once the result
// is loaded into the result register. Reset empties the queue.
// ----------------------------------------------------------------------------
module command_queue_calculator #(
    parameter int QUEUE_DEPTH = cqc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], operation[3:2], operand[35:4], drop_count[40:36],
    // start_value[72:41], zero fill
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value[31:0], queue_count[36:32], status[39:37]
    output logic [39:0]  m_axis_tdata
);
    import cqc_pkg::*;

    ctrl_t ctl;
    stat_t st;
    logic  ready;
    logic  in_fire;
    logic  out_valid_reg;
    logic [39:0] out_data_reg;
    logic signed [31:0] res_v;
    logic [4:0] res_c;
    logic [2:0] res_s;

    assign s_axis_tready = ready;
    assign in_fire = s_axis_tvalid && ready;

    cqc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_valid_reg && !m_axis_tready),
        .st       (st),
        .ctl      (ctl),
        .ready    (ready)
    );

    cqc_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .st           (st),
        .command      (s_axis_tdata[1:0]),
        .operation    (s_axis_tdata[3:2]),
        .operand      (s_axis_tdata[35:4]),
        .drop_count   (s_axis_tdata[40:36]),
        .start_value  (s_axis_tdata[72:41]),
        .result_value (res_v),
        .queue_count  (res_c),
        .status       (res_s)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
            out_data_reg <= {res_s, res_c, res_v};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
